/* rtl/core/csma_pkg.sv */
// Shared types, codes and defaults for the CSMA MAC controller.
`timescale 1ns / 1ps
package csma_pkg;

  localparam int PAYLOAD_W     = 32;
  localparam int TICKS_W       = 16;
  localparam int RETRY_W       = 8;
  localparam int LIMIT_W       = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int QUEUE_DEPTH_D = 16;

  localparam logic [LIMIT_W-1:0] BUFFER_LIMIT_RST  = LIMIT_W'(16);
  localparam logic [RETRY_W-1:0] MAX_BACKOFFS_RST  = RETRY_W'(4);
  localparam logic [TICKS_W-1:0] BACKOFF_DELAY_RST = TICKS_W'(100);
  localparam logic [RETRY_W-1:0] RETRY_SAT         = '1;

  // busy_req encoding for sense responses and transmit confirms
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BUSY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_LIMIT  = 2'd0,
    CFG_MAX_BACKOFFS  = 2'd1,
    CFG_BACKOFF_DELAY = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_ARRIVAL = 3'd0,
    CMD_SENSE   = 3'd1,
    CMD_CONFIRM = 3'd2,
    CMD_RETRY   = 3'd3,
    CMD_RECEIVE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SENSE   = 2'd0,
    KIND_TX      = 2'd1,
    KIND_DELIVER = 2'd2,
    KIND_WAIT    = 2'd3
  } kind_t;

  // Only idle, sense wait and confirm wait persist between items.
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_CS_RETRY   = 3'd1,
    PH_CS_WAITING = 3'd2,
    PH_TX_START   = 3'd3,
    PH_TX_WAITING = 3'd4,
    PH_TX_OVER    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [PAYLOAD_W-1:0] payload;
    logic                 busy_req;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [TICKS_W-1:0]   wait_ticks;
    logic                 last;
  } out_beat_t;

  // Results of one accepted item, handed to the output stage.
  typedef struct packed {
    logic      valid;
    logic      two;
    logic      tx;     // first beat takes its payload from the queue read
    out_beat_t r0;
    out_beat_t r1;
  } res_pair_t;

endpackage

/* rtl/core/csma_mac_controller_top.sv */
// CSMA MAC controller: packet queue RAM, event control and result output stage.
// Path: an accepted item's result beats are registered in the staging register,
// then enter the output register when it is free to take them.
// Throughput: one item per cycle while out_stall is low and items cause at most
// one result; an item with two results holds the input while its second beat waits.
// Reset (rst_n low, synchronous): phase idle, queue empty, retry count zero,
// registers to defaults; queue RAM contents are not cleared.
`timescale 1ns / 1ps
module csma_mac_controller_top #(
  parameter int QUEUE_DEPTH = csma_pkg::QUEUE_DEPTH_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [csma_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [csma_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  csma_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output csma_pkg::out_beat_t             out_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic                           in_accept;
  logic                           q_we;
  logic [PTR_W-1:0]               q_waddr;
  logic [csma_pkg::PAYLOAD_W-1:0] q_wdata;
  logic                           q_re;
  logic [PTR_W-1:0]               q_raddr;
  logic [csma_pkg::PAYLOAD_W-1:0] q_rdata;
  csma_pkg::res_pair_t            pair;

  assign in_accept = in_valid && !in_stall;

  csma_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_data   (in_data),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .q_re      (q_re),
    .q_raddr   (q_raddr),
    .pair      (pair)
  );

  csma_ram #(
    .WIDTH(csma_pkg::PAYLOAD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  csma_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair      (pair),
    .q_rdata   (q_rdata),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/csma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module csma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/csma_ctrl.sv */
// Event handling, phase machine, queue pointers and configuration registers.
`timescale 1ns / 1ps
module csma_ctrl #(
  parameter int QUEUE_DEPTH = csma_pkg::QUEUE_DEPTH_D,
  localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [csma_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [csma_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_accept,
  input  csma_pkg::in_beat_t                 in_data,
  output logic                               q_we,
  output logic [PTR_W-1:0]                   q_waddr,
  output logic [csma_pkg::PAYLOAD_W-1:0]     q_wdata,
  output logic                               q_re,
  output logic [PTR_W-1:0]                   q_raddr,
  output csma_pkg::res_pair_t                pair
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > csma_pkg::LIMIT_W) ? CNT_W : csma_pkg::LIMIT_W;

  logic [csma_pkg::LIMIT_W-1:0] buffer_limit_r;
  logic [csma_pkg::RETRY_W-1:0] max_backoffs_r;
  logic [csma_pkg::TICKS_W-1:0] backoff_delay_r;

  csma_pkg::phase_t             phase_r, phase_nxt;
  logic [PTR_W-1:0]             head_r, head_nxt;
  logic [PTR_W-1:0]             tail_r, tail_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [csma_pkg::RETRY_W-1:0] retry_r, retry_nxt;

  logic can_push;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic csma_pkg::out_beat_t mk_beat(
    input csma_pkg::kind_t              k,
    input logic [csma_pkg::PAYLOAD_W-1:0] p,
    input logic [csma_pkg::TICKS_W-1:0]   t
  );
    csma_pkg::out_beat_t b;
    b.kind        = k;
    b.out_payload = p;
    b.wait_ticks  = t;
    b.last        = 1'b0;
    mk_beat = b;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_limit_r  <= csma_pkg::BUFFER_LIMIT_RST;
      max_backoffs_r  <= csma_pkg::MAX_BACKOFFS_RST;
      backoff_delay_r <= csma_pkg::BACKOFF_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        csma_pkg::CFG_BUFFER_LIMIT:  buffer_limit_r  <= cfg_wdata[csma_pkg::LIMIT_W-1:0];
        csma_pkg::CFG_MAX_BACKOFFS:  max_backoffs_r  <= cfg_wdata[csma_pkg::RETRY_W-1:0];
        csma_pkg::CFG_BACKOFF_DELAY: backoff_delay_r <= cfg_wdata[csma_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csma_pkg::PH_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      retry_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      retry_r <= retry_nxt;
    end
  end

  assign can_push = (CMP_W'(count_r) < CMP_W'(buffer_limit_r)) &&
                    (count_r < CNT_W'(QUEUE_DEPTH));

  // The queue head is read on every accepted item; only a clear sense uses it,
  // and that item never moves the head.
  assign q_re     = in_accept;
  assign q_raddr  = head_r;
  assign q_waddr  = tail_r;
  assign q_wdata  = in_data.payload;

  always_comb begin
    csma_pkg::phase_t             ev;
    logic [1:0]                   n;
    logic [csma_pkg::RETRY_W-1:0] retry_sat;

    phase_nxt = phase_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    retry_nxt = retry_r;
    q_we      = 1'b0;
    pair      = '0;
    n         = 2'd0;
    ev        = phase_r;
    retry_sat = (retry_r == csma_pkg::RETRY_SAT) ? retry_r
                                                 : retry_r + csma_pkg::RETRY_W'(1);

    if (in_accept) begin
      case (in_data.cmd)
        csma_pkg::CMD_ARRIVAL: begin
          if (can_push) begin
            q_we      = 1'b1;
            tail_nxt  = next_ptr(tail_r);
            count_nxt = count_r + CNT_W'(1);
          end
        end
        csma_pkg::CMD_SENSE: begin
          if (count_r == '0) begin
            ev = csma_pkg::PH_IDLE;
          end else if (in_data.busy_req == csma_pkg::STATUS_BUSY) begin
            retry_nxt = retry_sat;
            if (retry_sat < max_backoffs_r) begin
              pair.r0 = mk_beat(csma_pkg::KIND_WAIT, '0, backoff_delay_r);
              n       = 2'd1;
              ev      = csma_pkg::PH_CS_WAITING;
            end else begin
              // out of retries: drop the head packet
              head_nxt  = next_ptr(head_r);
              count_nxt = count_r - CNT_W'(1);
              ev        = csma_pkg::PH_IDLE;
            end
          end else begin
            ev = csma_pkg::PH_TX_START;
          end
        end
        csma_pkg::CMD_CONFIRM: begin
          ev = (in_data.busy_req == csma_pkg::STATUS_BUSY) ? csma_pkg::PH_IDLE
                                                            : csma_pkg::PH_TX_OVER;
        end
        csma_pkg::CMD_RETRY: begin
          ev = csma_pkg::PH_CS_RETRY;
        end
        csma_pkg::CMD_RECEIVE: begin
          pair.r0 = mk_beat(csma_pkg::KIND_DELIVER, in_data.payload, '0);
          n       = 2'd1;
        end
        default: ;
      endcase

      phase_nxt = ev;
      case (ev)
        csma_pkg::PH_IDLE: begin
          if (count_nxt != '0) begin
            retry_nxt = '0;
            if (n == 2'd0) pair.r0 = mk_beat(csma_pkg::KIND_SENSE, '0, '0);
            else           pair.r1 = mk_beat(csma_pkg::KIND_SENSE, '0, '0);
            n         = n + 2'd1;
            phase_nxt = csma_pkg::PH_CS_WAITING;
          end
        end
        csma_pkg::PH_CS_RETRY: begin
          if (n == 2'd0) pair.r0 = mk_beat(csma_pkg::KIND_SENSE, '0, '0);
          else           pair.r1 = mk_beat(csma_pkg::KIND_SENSE, '0, '0);
          n         = n + 2'd1;
          phase_nxt = csma_pkg::PH_CS_WAITING;
        end
        csma_pkg::PH_TX_START: begin
          // payload filled in by the output stage from the registered queue read
          pair.r0   = mk_beat(csma_pkg::KIND_TX, '0, '0);
          pair.tx   = 1'b1;
          n         = n + 2'd1;
          phase_nxt = csma_pkg::PH_TX_WAITING;
        end
        csma_pkg::PH_TX_OVER: begin
          if (count_nxt != '0) begin
            head_nxt  = next_ptr(head_r);
            count_nxt = count_nxt - CNT_W'(1);
          end
          phase_nxt = csma_pkg::PH_IDLE;
        end
        default: ;
      endcase

      pair.valid = (n != 2'd0);
      pair.two   = (n == 2'd2);
      if (n == 2'd1) pair.r0.last = 1'b1;
      if (n == 2'd2) pair.r1.last = 1'b1;
    end
  end

endmodule

/* rtl/core/csma_outq.sv */
// Result staging: holds one item's beats and drains them through an output register.
`timescale 1ns / 1ps
module csma_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  csma_pkg::res_pair_t            pair,
  input  logic [csma_pkg::PAYLOAD_W-1:0] q_rdata,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output csma_pkg::out_beat_t            out_data
);

  logic                p_valid_r, p_valid_nxt;
  logic                p_idx_r, p_idx_nxt;
  logic                p_two_r;
  logic                p_tx_r;
  csma_pkg::out_beat_t p_res0_r, p_res1_r;
  logic                out_valid_r, out_valid_nxt;
  csma_pkg::out_beat_t out_data_r, out_data_nxt;

  logic                out_ready;
  logic                p_last;
  logic                p_move;
  csma_pkg::out_beat_t head_beat;

  assign out_ready = !out_valid_r || !out_stall;
  assign p_last    = !p_two_r || p_idx_r;
  assign p_move    = p_valid_r && out_ready;
  // take a new item once the staged one is gone or leaves with this beat
  assign in_stall  = p_valid_r && !(out_ready && p_last);

  always_comb begin
    head_beat = p_res0_r;
    if (p_tx_r) head_beat.out_payload = q_rdata;
  end

  always_comb begin
    p_valid_nxt   = p_valid_r;
    p_idx_nxt     = p_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = p_valid_r;
      out_data_nxt  = p_idx_r ? p_res1_r : head_beat;
    end
    if (p_move) begin
      if (p_last) p_valid_nxt = 1'b0;
      else        p_idx_nxt   = 1'b1;
    end
    if (pair.valid) begin
      p_valid_nxt = 1'b1;
      p_idx_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      p_idx_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      p_idx_r     <= p_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pair.valid) begin
      p_two_r  <= pair.two;
      p_tx_r   <= pair.tx;
      p_res0_r <= pair.r0;
      p_res1_r <= pair.r1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/csma_chk.sv */
// Port-level checks for the CSMA MAC controller, bound to the top level.
`timescale 1ns / 1ps
module csma_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input csma_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input csma_pkg::out_beat_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // only a delivery can be followed by another beat of the same item
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != csma_pkg::KIND_DELIVER) |-> out_data.last)
    else $error("non-delivery beat without last");

  // no payload on sense or wait beats, and no wait length on sense beats
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.kind == csma_pkg::KIND_SENSE) ||
                  (out_data.kind == csma_pkg::KIND_WAIT))
    |-> (out_data.out_payload == '0) &&
        ((out_data.kind == csma_pkg::KIND_WAIT) || (out_data.wait_ticks == '0)))
    else $error("stray payload or wait length");

  // an accepted receive indication, with the output empty, reaches the output through the staging and output registers
  a_recv: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == csma_pkg::CMD_RECEIVE) && !out_valid
    |=> ##1 out_valid)
    else $error("receive indication produced no result");

endmodule

bind csma_mac_controller_top csma_chk u_csma_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
